[src/dbgf_pkg.sv]
// ----------------------------------------------------------------------------
// dbgf_pkg: shared constants and helpers of the disk and bulge gravity field
// Register indexes, result limits and the final limit and sign stage helpers.
// ----------------------------------------------------------------------------
package dbgf_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 31;
    localparam int POS_W     = 32;
    localparam int RES_W     = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_DISK_A  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_B  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_M  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BULGE_R = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BULGE_M = 3'd4;

    localparam logic [CFG_W-1:0] RST_DISK_A  = 31'd0;
    localparam logic [CFG_W-1:0] RST_DISK_B  = 31'd65536;
    localparam logic [CFG_W-1:0] RST_DISK_M  = 31'd65536;
    localparam logic [CFG_W-1:0] RST_BULGE_R = 31'd65536;
    localparam logic [CFG_W-1:0] RST_BULGE_M = 31'd65536;

    // Magnitude limit of one body's term, 2^47.
    localparam logic [RES_W-1:0] LIM47   = 48'h8000_0000_0000;
    localparam logic [RES_W-1:0] RES_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [RES_W-1:0] RES_MIN = 48'h8000_0000_0000;

    // Limits a quotient to 2^47; ovf marks a quotient of 2^48 or more.
    function automatic logic [RES_W-1:0] f_limit(input logic ovf,
                                                 input logic [RES_W-1:0] quo);
        logic big;
        big = ovf || (quo > LIM47);
        return big ? LIM47 : quo;
    endfunction

    // Sums two attraction magnitudes and points them against the coordinate.
    function automatic logic [RES_W-1:0] f_toward(input logic neg,
                                                  input logic [RES_W-1:0] a,
                                                  input logic [RES_W-1:0] b);
        logic [RES_W:0] sum;
        logic [RES_W:0] lim;
        sum = {1'b0, a} + {1'b0, b};
        lim = {1'b0, LIM47};
        if (neg) begin
            return (sum >= lim) ? RES_MAX : sum[RES_W-1:0];
        end else begin
            return (sum >= lim) ? RES_MIN : RES_W'(~sum[RES_W-1:0] + 48'd1);
        end
    endfunction

endpackage

[src/dbgf_if.sv]
// ----------------------------------------------------------------------------
// dbgf_if: channel interfaces of the gravity field block
// Position stream, field result stream and configuration write channel.
// ----------------------------------------------------------------------------
interface dbgf_pos_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    modport source(output valid, pos_x, pos_y, pos_z, input ready);
    modport sink(input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface dbgf_field_if;
    logic        valid;
    logic        ready;
    logic signed [47:0] acc_x;
    logic signed [47:0] acc_y;
    logic signed [47:0] acc_z;
    logic signed [47:0] potential;
    modport source(output valid, acc_x, acc_y, acc_z, potential, input ready);
    modport sink(input valid, acc_x, acc_y, acc_z, potential, output ready);
endinterface

interface dbgf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [30:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

[src/dbgf_isqrt.sv]
// ----------------------------------------------------------------------------
// dbgf_isqrt: pipelined integer square root
// Floor root, one result bit per register stage, several lanes in lockstep.
// ----------------------------------------------------------------------------
module dbgf_isqrt #(
    parameter int LANES  = 1,
    parameter int IN_W   = 64,
    parameter int SIDE_W = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic [LANES-1:0][IN_W-1:0]         i_x,
    input  logic [SIDE_W-1:0]                  i_side,
    output logic                               o_valid,
    output logic [LANES-1:0][IN_W/2-1:0]       o_root,
    output logic [SIDE_W-1:0]                  o_side
);

    localparam int OUT_W = IN_W / 2;
    localparam int RW    = OUT_W + 2;

    logic [LANES-1:0][RW-1:0]    r_rem  [0:OUT_W-1];
    logic [LANES-1:0][OUT_W-1:0] r_root [0:OUT_W-1];
    logic [LANES-1:0][IN_W-1:0]  r_val  [0:OUT_W-1];
    logic [SIDE_W-1:0]           r_side [0:OUT_W-1];
    logic [OUT_W-1:0]            r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[OUT_W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int i = 1; i < OUT_W; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    genvar k, l;
    generate
        for (k = 0; k < OUT_W; k++) begin : g_stage
            for (l = 0; l < LANES; l++) begin : g_lane
                logic [RW-1:0]    p_rem;
                logic [OUT_W-1:0] p_root;
                logic [IN_W-1:0]  p_val;
                logic [RW-1:0]    rem_sh;
                logic [RW-1:0]    trial;
                logic             ge;
                if (k == 0) begin : g_first
                    assign p_rem  = '0;
                    assign p_root = '0;
                    assign p_val  = i_x[l];
                end else begin : g_next
                    assign p_rem  = r_rem[k-1][l];
                    assign p_root = r_root[k-1][l];
                    assign p_val  = r_val[k-1][l];
                end
                // Bring down the next two bits and try the next root bit.
                assign rem_sh = {p_rem[OUT_W-1:0], p_val[IN_W-1:IN_W-2]};
                assign trial  = {p_root, 2'b01};
                assign ge     = rem_sh >= trial;
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[k][l]  <= ge ? RW'(rem_sh - trial) : rem_sh;
                        r_root[k][l] <= {p_root[OUT_W-2:0], ge};
                        r_val[k][l]  <= {p_val[IN_W-3:0], 2'b00};
                    end
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[OUT_W-1];
    assign o_root  = r_root[OUT_W-1];
    assign o_side  = r_side[OUT_W-1];

endmodule

[src/dbgf_div.sv]
// ----------------------------------------------------------------------------
// dbgf_div: pipelined restoring divider with a bounded quotient
// An entry stage flags quotients of 2^Q_W or more, then one quotient bit is
// formed per register stage. Several lanes run in lockstep.
// ----------------------------------------------------------------------------
module dbgf_div #(
    parameter int LANES  = 1,
    parameter int N_W    = 103,
    parameter int D_W    = 101,
    parameter int Q_W    = 48,
    parameter int SIDE_W = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [LANES-1:0][N_W-1:0]   i_num,
    input  logic [LANES-1:0][D_W-1:0]   i_den,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [LANES-1:0][Q_W-1:0]   o_quo,
    output logic [LANES-1:0]            o_ovf,
    output logic [SIDE_W-1:0]           o_side
);

    localparam int CW = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

    logic [LANES-1:0][D_W-1:0] r_rem  [0:Q_W];
    logic [LANES-1:0][D_W-1:0] r_den  [0:Q_W];
    logic [LANES-1:0][Q_W-1:0] r_low  [0:Q_W];
    logic [LANES-1:0][Q_W-1:0] r_quo  [0:Q_W];
    logic [LANES-1:0]          r_ovf  [0:Q_W];
    logic [SIDE_W-1:0]         r_side [0:Q_W];
    logic [Q_W:0]              r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Q_W-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int i = 1; i <= Q_W; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    genvar k, l;
    generate
        for (l = 0; l < LANES; l++) begin : g_init
            logic [CW-1:0] num_w;
            logic [CW-1:0] den_w;
            assign num_w = CW'(i_num[l]);
            assign den_w = CW'({i_den[l], {Q_W{1'b0}}});
            // The upper numerator part is below the divisor unless flagged.
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ovf[0][l] <= num_w >= den_w;
                    r_rem[0][l] <= D_W'(i_num[l] >> Q_W);
                    r_low[0][l] <= i_num[l][Q_W-1:0];
                    r_den[0][l] <= i_den[l];
                    r_quo[0][l] <= '0;
                end
            end
        end

        for (k = 1; k <= Q_W; k++) begin : g_step
            for (l = 0; l < LANES; l++) begin : g_lane
                logic [D_W:0] trial;
                logic [D_W:0] dsr;
                logic         ge;
                assign trial = {r_rem[k-1][l], r_low[k-1][l][Q_W-1]};
                assign dsr   = {1'b0, r_den[k-1][l]};
                assign ge    = trial >= dsr;
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[k][l] <= ge ? D_W'(trial - dsr) : trial[D_W-1:0];
                        r_low[k][l] <= {r_low[k-1][l][Q_W-2:0], 1'b0};
                        r_den[k][l] <= r_den[k-1][l];
                        r_quo[k][l] <= {r_quo[k-1][l][Q_W-2:0], ge};
                        r_ovf[k][l] <= r_ovf[k-1][l];
                    end
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[Q_W];
    assign o_quo   = r_quo[Q_W];
    assign o_ovf   = r_ovf[Q_W];
    assign o_side  = r_side[Q_W];

endmodule

[src/disk_bulge_gravity_field.sv]
// ----------------------------------------------------------------------------
// disk_bulge_gravity_field: disk plus bulge gravity field evaluator
// Acceleration and potential of a Miyamoto-Nagai disk and a Plummer sphere.
// ----------------------------------------------------------------------------
// Usage:
//   i_pos carries one particle position (Q16.16) per transaction; o_field
//   returns the summed acceleration and potential (Q24.24, saturating) of
//   that position, one result per position, in order.
//   i_cfg writes the five shape and mass registers by index; it is always
//   ready. Registers must be written only while no position is in flight;
//   the block itself does not enforce this. Indexes above four are ignored.
// Pipeline:
//   One position is taken every cycle while o_field is not held off. A
//   result passes through a 32-step and a 34-step square root pipeline
//   and two 49-step divider pipelines in series, the second dividing by
//   the disk's vertical term.
// Reset and stalls:
//   Reset empties the pipeline and loads the default registers. When the
//   receiver holds off o_field, the whole pipeline freezes and i_pos.ready
//   drops; it is high whenever the output register is empty or being read.
// ----------------------------------------------------------------------------
module disk_bulge_gravity_field (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dbgf_pos_if.sink     i_pos,
    dbgf_field_if.source o_field,
    dbgf_cfg_if.sink     i_cfg
);

    typedef struct packed {
        logic [2:0]  neg;
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] mz;
        logic [63:0] xy2;
    } t_sq_side;

    typedef struct packed {
        logic [2:0]  neg;
        logic [31:0] q1;
        logic [32:0] ap;
        logic [32:0] p;
        logic [97:0] pden;
        logic [66:0] s;
        logic [62:0] mdx;
        logic [62:0] mdy;
        logic [62:0] mdz;
        logic [62:0] mbx;
        logic [62:0] mby;
        logic [62:0] mbz;
    } t_dr_side;

    typedef struct packed {
        logic [2:0]  neg;
        logic [31:0] q1;
        logic [32:0] ap;
    } t_d1_side;

    typedef struct packed {
        logic [2:0]  neg;
        logic        zb_big;
        logic [47:0] dx;
        logic [47:0] dy;
        logic [47:0] bx;
        logic [47:0] by;
        logic [47:0] bz;
        logic [47:0] pd;
        logic [47:0] pb;
    } t_d2_side;

    // Configuration registers.
    logic [30:0] r_disk_a, r_disk_b, r_disk_m, r_bulge_r, r_bulge_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_a  <= dbgf_pkg::RST_DISK_A;
            r_disk_b  <= dbgf_pkg::RST_DISK_B;
            r_disk_m  <= dbgf_pkg::RST_DISK_M;
            r_bulge_r <= dbgf_pkg::RST_BULGE_R;
            r_bulge_m <= dbgf_pkg::RST_BULGE_M;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                dbgf_pkg::CFG_DISK_A:  r_disk_a  <= i_cfg.data;
                dbgf_pkg::CFG_DISK_B:  r_disk_b  <= i_cfg.data;
                dbgf_pkg::CFG_DISK_M:  r_disk_m  <= i_cfg.data;
                dbgf_pkg::CFG_BULGE_R: r_bulge_r <= i_cfg.data;
                dbgf_pkg::CFG_BULGE_M: r_bulge_m <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // The whole pipeline advances unless a finished result is held.
    logic r_out_valid;
    logic w_adv;

    assign w_adv       = !r_out_valid || o_field.ready;
    assign i_pos.ready = w_adv;

    // Stage A: magnitudes and signs.
    logic        r_a_valid;
    logic [2:0]  r_a_neg;
    logic [31:0] r_a_mx, r_a_my, r_a_mz;

    // Stage B: squares.
    logic        r_b_valid;
    logic [2:0]  r_b_neg;
    logic [31:0] r_b_mx, r_b_my, r_b_mz;
    logic [63:0] r_b_x2, r_b_y2, r_b_z2;
    logic [61:0] r_b_b2;

    // Stage C: sums ahead of the first roots.
    logic        r_c_valid;
    logic [63:0] r_c_zb2, r_c_r2;
    t_sq_side    r_c_side;

    logic                  w_s1_valid;
    logic [1:0][31:0]      w_s1_root;
    t_sq_side              w_s1_side;

    dbgf_isqrt #(.LANES(2), .IN_W(64), .SIDE_W($bits(t_sq_side))) u_sqrt_qr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_c_valid),
        .i_x     ({r_c_r2, r_c_zb2}),
        .i_side  (r_c_side),
        .o_valid (w_s1_valid),
        .o_root  (w_s1_root),
        .o_side  (w_s1_side)
    );

    // Stage D: clamped roots and sums.
    logic        r_d_valid;
    logic [2:0]  r_d_neg;
    logic [31:0] r_d_mx, r_d_my, r_d_mz;
    logic [63:0] r_d_xy2;
    logic [31:0] r_d_q1, r_d_rp;
    logic [32:0] r_d_ap, r_d_p;

    logic [31:0] w_q1, w_rp;
    logic [32:0] w_p;

    always_comb begin
        w_q1 = (w_s1_root[0] == 32'd0) ? 32'd1 : w_s1_root[0];
        w_rp = (w_s1_root[1] == 32'd0) ? 32'd1 : w_s1_root[1];
        w_p  = 33'(w_s1_root[1]) + 33'(r_bulge_r);
        // A zero core radius at the origin still leaves a nonzero divisor.
        if (w_p == 33'd0) begin
            w_p = 33'd1;
        end
    end

    // Stage E: products.
    logic        r_e_valid;
    logic [2:0]  r_e_neg;
    logic [63:0] r_e_xy2;
    logic [31:0] r_e_q1, r_e_rp;
    logic [32:0] r_e_ap, r_e_p;
    logic [65:0] r_e_ap2, r_e_pp;
    logic [62:0] r_e_mdx, r_e_mdy, r_e_mdz, r_e_mbx, r_e_mby, r_e_mbz;

    // Stage F: disk sum and split sphere denominator.
    logic        r_f_valid;
    logic [2:0]  r_f_neg;
    logic [31:0] r_f_q1;
    logic [32:0] r_f_ap, r_f_p;
    logic [66:0] r_f_s;
    logic [64:0] r_f_pd_lo, r_f_pd_hi;
    logic [62:0] r_f_mdx, r_f_mdy, r_f_mdz, r_f_mbx, r_f_mby, r_f_mbz;

    // Stage G: sphere denominator.
    logic        r_g_valid;
    t_dr_side    r_g_side;

    logic        w_s2_valid;
    logic [33:0] w_s2_root;
    t_dr_side    w_s2_side;

    dbgf_isqrt #(.LANES(1), .IN_W(68), .SIDE_W($bits(t_dr_side))) u_sqrt_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_g_valid),
        .i_x     (68'(r_g_side.s)),
        .i_side  (r_g_side),
        .o_valid (w_s2_valid),
        .o_root  (w_s2_root),
        .o_side  (w_s2_side)
    );

    // Stage H: split disk denominator.
    logic        r_h_valid;
    t_dr_side    r_h_side;
    logic [33:0] r_h_dr;
    logic [67:0] r_h_dd_lo;
    logic [66:0] r_h_dd_hi;

    // Stage I: disk denominator, divider operands.
    logic         r_i_valid;
    t_dr_side     r_i_side;
    logic [33:0]  r_i_dr;
    logic [100:0] r_i_dden;

    logic [7:0][102:0] w_d1_num;
    logic [7:0][100:0] w_d1_den;
    t_d1_side          w_d1_in_side;

    // Lanes: disk x, disk y, disk z base, sphere x, y, z, disk and sphere
    // potential.
    always_comb begin
        w_d1_num[0] = {r_i_side.mdx, 40'd0};
        w_d1_num[1] = {r_i_side.mdy, 40'd0};
        w_d1_num[2] = {r_i_side.mdz, 40'd0};
        w_d1_num[3] = {r_i_side.mbx, 40'd0};
        w_d1_num[4] = {r_i_side.mby, 40'd0};
        w_d1_num[5] = {r_i_side.mbz, 40'd0};
        w_d1_num[6] = 103'({r_disk_m, 24'd0});
        w_d1_num[7] = 103'({r_bulge_m, 24'd0});
        w_d1_den[0] = r_i_dden;
        w_d1_den[1] = r_i_dden;
        w_d1_den[2] = r_i_dden;
        w_d1_den[3] = 101'(r_i_side.pden);
        w_d1_den[4] = 101'(r_i_side.pden);
        w_d1_den[5] = 101'(r_i_side.pden);
        w_d1_den[6] = 101'(r_i_dr);
        w_d1_den[7] = 101'(r_i_side.p);
        w_d1_in_side.neg = r_i_side.neg;
        w_d1_in_side.q1  = r_i_side.q1;
        w_d1_in_side.ap  = r_i_side.ap;
    end

    logic             w_d1_valid;
    logic [7:0][47:0] w_d1_quo;
    logic [7:0]       w_d1_ovf;
    t_d1_side         w_d1_side;

    dbgf_div #(.LANES(8), .N_W(103), .D_W(101), .Q_W(48),
               .SIDE_W($bits(t_d1_side))) u_div_main (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_i_valid),
        .i_num   (w_d1_num),
        .i_den   (w_d1_den),
        .i_side  (w_d1_in_side),
        .o_valid (w_d1_valid),
        .o_quo   (w_d1_quo),
        .o_ovf   (w_d1_ovf),
        .o_side  (w_d1_side)
    );

    // Stage J: limits and split disk z product.
    logic        r_j_valid;
    t_d2_side    r_j_side;
    logic [31:0] r_j_q1;
    logic [56:0] r_j_z_lo;
    logic [55:0] r_j_z_hi;

    logic        w_zb_big;
    logic [46:0] w_zbase;

    assign w_zb_big = w_d1_ovf[2] || w_d1_quo[2][47];
    assign w_zbase  = w_d1_quo[2][46:0];

    // Stage K: disk z numerator.
    logic        r_k_valid;
    t_d2_side    r_k_side;
    logic [31:0] r_k_q1;
    logic [79:0] r_k_znum;

    logic        w_d2_valid;
    logic [47:0] w_d2_quo;
    logic        w_d2_ovf;
    t_d2_side    w_d2_side;

    dbgf_div #(.LANES(1), .N_W(80), .D_W(32), .Q_W(48),
               .SIDE_W($bits(t_d2_side))) u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_k_valid),
        .i_num   (r_k_znum),
        .i_den   (r_k_q1),
        .i_side  (r_k_side),
        .o_valid (w_d2_valid),
        .o_quo   (w_d2_quo),
        .o_ovf   (w_d2_ovf),
        .o_side  (w_d2_side)
    );

    logic [47:0] w_mzd;

    assign w_mzd = w_d2_side.zb_big ? dbgf_pkg::LIM47
                                    : dbgf_pkg::f_limit(w_d2_ovf, w_d2_quo);

    logic [47:0] r_out_acc_x, r_out_acc_y, r_out_acc_z, r_out_pot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_e_valid   <= 1'b0;
            r_f_valid   <= 1'b0;
            r_g_valid   <= 1'b0;
            r_h_valid   <= 1'b0;
            r_i_valid   <= 1'b0;
            r_j_valid   <= 1'b0;
            r_k_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid   <= i_pos.valid;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_d_valid   <= w_s1_valid;
            r_e_valid   <= r_d_valid;
            r_f_valid   <= r_e_valid;
            r_g_valid   <= r_f_valid;
            r_h_valid   <= w_s2_valid;
            r_i_valid   <= r_h_valid;
            r_j_valid   <= w_d1_valid;
            r_k_valid   <= r_j_valid;
            r_out_valid <= w_d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // A
            r_a_neg <= {i_pos.pos_z[31], i_pos.pos_y[31], i_pos.pos_x[31]};
            r_a_mx  <= i_pos.pos_x[31] ? 32'(~i_pos.pos_x + 32'sd1) : 32'(i_pos.pos_x);
            r_a_my  <= i_pos.pos_y[31] ? 32'(~i_pos.pos_y + 32'sd1) : 32'(i_pos.pos_y);
            r_a_mz  <= i_pos.pos_z[31] ? 32'(~i_pos.pos_z + 32'sd1) : 32'(i_pos.pos_z);
            // B
            r_b_neg <= r_a_neg;
            r_b_mx  <= r_a_mx;
            r_b_my  <= r_a_my;
            r_b_mz  <= r_a_mz;
            r_b_x2  <= r_a_mx * r_a_mx;
            r_b_y2  <= r_a_my * r_a_my;
            r_b_z2  <= r_a_mz * r_a_mz;
            r_b_b2  <= r_disk_b * r_disk_b;
            // C
            r_c_zb2      <= r_b_z2 + 64'(r_b_b2);
            r_c_r2       <= r_b_x2 + r_b_y2 + r_b_z2;
            r_c_side.neg <= r_b_neg;
            r_c_side.mx  <= r_b_mx;
            r_c_side.my  <= r_b_my;
            r_c_side.mz  <= r_b_mz;
            r_c_side.xy2 <= r_b_x2 + r_b_y2;
            // D
            r_d_neg <= w_s1_side.neg;
            r_d_mx  <= w_s1_side.mx;
            r_d_my  <= w_s1_side.my;
            r_d_mz  <= w_s1_side.mz;
            r_d_xy2 <= w_s1_side.xy2;
            r_d_q1  <= w_q1;
            r_d_rp  <= w_rp;
            r_d_ap  <= 33'(r_disk_a) + 33'(w_q1);
            r_d_p   <= w_p;
            // E
            r_e_neg <= r_d_neg;
            r_e_xy2 <= r_d_xy2;
            r_e_q1  <= r_d_q1;
            r_e_rp  <= r_d_rp;
            r_e_ap  <= r_d_ap;
            r_e_p   <= r_d_p;
            r_e_ap2 <= r_d_ap * r_d_ap;
            r_e_pp  <= r_d_p * r_d_p;
            r_e_mdx <= r_disk_m * r_d_mx;
            r_e_mdy <= r_disk_m * r_d_my;
            r_e_mdz <= r_disk_m * r_d_mz;
            r_e_mbx <= r_bulge_m * r_d_mx;
            r_e_mby <= r_bulge_m * r_d_my;
            r_e_mbz <= r_bulge_m * r_d_mz;
            // F
            r_f_neg   <= r_e_neg;
            r_f_q1    <= r_e_q1;
            r_f_ap    <= r_e_ap;
            r_f_p     <= r_e_p;
            r_f_s     <= 67'(r_e_xy2) + 67'(r_e_ap2);
            r_f_pd_lo <= r_e_pp[32:0] * r_e_rp;
            r_f_pd_hi <= r_e_pp[65:33] * r_e_rp;
            r_f_mdx   <= r_e_mdx;
            r_f_mdy   <= r_e_mdy;
            r_f_mdz   <= r_e_mdz;
            r_f_mbx   <= r_e_mbx;
            r_f_mby   <= r_e_mby;
            r_f_mbz   <= r_e_mbz;
            // G
            r_g_side.neg  <= r_f_neg;
            r_g_side.q1   <= r_f_q1;
            r_g_side.ap   <= r_f_ap;
            r_g_side.p    <= r_f_p;
            r_g_side.pden <= 98'(r_f_pd_lo) + (98'(r_f_pd_hi) << 33);
            r_g_side.s    <= r_f_s;
            r_g_side.mdx  <= r_f_mdx;
            r_g_side.mdy  <= r_f_mdy;
            r_g_side.mdz  <= r_f_mdz;
            r_g_side.mbx  <= r_f_mbx;
            r_g_side.mby  <= r_f_mby;
            r_g_side.mbz  <= r_f_mbz;
            // H
            r_h_side  <= w_s2_side;
            r_h_dr    <= w_s2_root;
            r_h_dd_lo <= w_s2_side.s[33:0] * w_s2_root;
            r_h_dd_hi <= w_s2_side.s[66:34] * w_s2_root;
            // I
            r_i_side <= r_h_side;
            r_i_dr   <= r_h_dr;
            r_i_dden <= 101'(r_h_dd_lo) + (101'(r_h_dd_hi) << 34);
            // J
            r_j_side.neg    <= w_d1_side.neg;
            r_j_side.zb_big <= w_zb_big;
            r_j_side.dx     <= dbgf_pkg::f_limit(w_d1_ovf[0], w_d1_quo[0]);
            r_j_side.dy     <= dbgf_pkg::f_limit(w_d1_ovf[1], w_d1_quo[1]);
            r_j_side.bx     <= dbgf_pkg::f_limit(w_d1_ovf[3], w_d1_quo[3]);
            r_j_side.by     <= dbgf_pkg::f_limit(w_d1_ovf[4], w_d1_quo[4]);
            r_j_side.bz     <= dbgf_pkg::f_limit(w_d1_ovf[5], w_d1_quo[5]);
            r_j_side.pd     <= dbgf_pkg::f_limit(w_d1_ovf[6], w_d1_quo[6]);
            r_j_side.pb     <= dbgf_pkg::f_limit(w_d1_ovf[7], w_d1_quo[7]);
            r_j_q1          <= w_d1_side.q1;
            r_j_z_lo        <= w_zbase[23:0] * w_d1_side.ap;
            r_j_z_hi        <= w_zbase[46:24] * w_d1_side.ap;
            // K
            r_k_side <= r_j_side;
            r_k_q1   <= r_j_q1;
            r_k_znum <= 80'(r_j_z_lo) + (80'(r_j_z_hi) << 24);
            // Output
            r_out_acc_x <= dbgf_pkg::f_toward(w_d2_side.neg[0], w_d2_side.dx, w_d2_side.bx);
            r_out_acc_y <= dbgf_pkg::f_toward(w_d2_side.neg[1], w_d2_side.dy, w_d2_side.by);
            r_out_acc_z <= dbgf_pkg::f_toward(w_d2_side.neg[2], w_mzd, w_d2_side.bz);
            r_out_pot   <= dbgf_pkg::f_toward(1'b0, w_d2_side.pd, w_d2_side.pb);
        end
    end

    assign o_field.valid     = r_out_valid;
    assign o_field.acc_x     = r_out_acc_x;
    assign o_field.acc_y     = r_out_acc_y;
    assign o_field.acc_z     = r_out_acc_z;
    assign o_field.potential = r_out_pot;

endmodule

[src/dbgf_checker.sv]
// ----------------------------------------------------------------------------
// dbgf_checker: port-level checks of the gravity field block
// Watches the position and field channels and is bound to the top level.
// ----------------------------------------------------------------------------
module dbgf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [47:0] i_acc_x,
    input logic [47:0] i_acc_y,
    input logic [47:0] i_acc_z,
    input logic [47:0] i_potential
);

    // A held result stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result transaction dropped while stalled");

    // A held result keeps its payload.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable({i_acc_x, i_acc_y, i_acc_z, i_potential}))
        else $error("result payload changed while stalled");

    // The input side takes a position exactly when the output can move.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow the output stage");

    // Both bodies attract, so the potential is never positive.
    a_pot_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_potential[47] || i_potential == 48'd0))
        else $error("positive potential");

    // Nothing is offered in the first cycle after reset is released.
    a_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !i_out_valid)
        else $error("result offered after reset");

endmodule

bind disk_bulge_gravity_field dbgf_checker u_dbgf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pos.ready),
    .i_out_valid (o_field.valid),
    .i_out_ready (o_field.ready),
    .i_acc_x     (o_field.acc_x),
    .i_acc_y     (o_field.acc_y),
    .i_acc_z     (o_field.acc_z),
    .i_potential (o_field.potential)
);

[test/dbgf_tb_if.sv]
// ----------------------------------------------------------------------------
// dbgf_tb_if: test-side view of the gravity field channels
// The channel interfaces of the block are reused as they are; this file holds
// the small record type that the checker keeps for each expected result.
// ----------------------------------------------------------------------------
package dbgf_tb_pkg;

    typedef struct packed {
        logic [dbgf_pkg::RES_W-1:0] acc_x;
        logic [dbgf_pkg::RES_W-1:0] acc_y;
        logic [dbgf_pkg::RES_W-1:0] acc_z;
        logic [dbgf_pkg::RES_W-1:0] potential;
    } t_field;

endpackage

[test/dbgf_checker.sv]
// ----------------------------------------------------------------------------
// dbgf_scoreboard: field predictor and result scoreboard
// Watches the configuration, position and result channels, computes the
// expected field of every accepted position and compares it in order.
// ----------------------------------------------------------------------------
module dbgf_scoreboard (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dbgf_pos_if      i_pos,
    dbgf_field_if    i_field,
    dbgf_cfg_if      i_cfg,
    output int       o_errors,
    output int       o_pending
);

    logic [63:0]         scale_a, scale_b, mass_d, core_r, mass_b;
    dbgf_tb_pkg::t_field field_q[$];
    int                  err_cnt = 0;

    function automatic logic [63:0] root_of(input logic [127:0] v);
        logic [63:0]  res;
        logic [63:0]  t;
        res = '0;
        for (int i = 63; i >= 0; i--) begin
            t = res | (64'd1 << i);
            if (128'(t) * 128'(t) <= v) res = t;
        end
        return res;
    endfunction

    function automatic logic [63:0] clip47(input logic [127:0] m);
        return (m > 128'(dbgf_pkg::LIM47)) ? 64'(dbgf_pkg::LIM47) : m[63:0];
    endfunction

    // Attraction points against the coordinate.
    function automatic logic signed [63:0] against(input logic neg,
                                                   input logic [63:0] m);
        return neg ? $signed(m) : -$signed(m);
    endfunction

    function automatic logic [dbgf_pkg::RES_W-1:0] sat48(input logic signed [63:0] v);
        if (v > $signed(64'(dbgf_pkg::RES_MAX))) return dbgf_pkg::RES_MAX;
        if (v < -$signed(64'(dbgf_pkg::LIM47))) return dbgf_pkg::RES_MIN;
        return v[dbgf_pkg::RES_W-1:0];
    endfunction

    function automatic dbgf_tb_pkg::t_field field_at(input logic signed [31:0] px,
                                                     input logic signed [31:0] py,
                                                     input logic signed [31:0] pz);
        logic [63:0]  mx, my, mz, x2, y2, z2, q, ap, dr, r, rp, p, mzd;
        logic [127:0] s, dden, pden, zb;
        logic [63:0]  ax_d, ay_d, ax_b, ay_b, az_b;
        dbgf_tb_pkg::t_field f;
        mx = px < 0 ? 64'(-64'(px)) : 64'(px);
        my = py < 0 ? 64'(-64'(py)) : 64'(py);
        mz = pz < 0 ? 64'(-64'(pz)) : 64'(pz);
        x2 = mx * mx; y2 = my * my; z2 = mz * mz;
        q = root_of(128'(z2 + scale_b * scale_b));
        if (q == 0) q = 1;
        ap = scale_a + q;
        s = 128'(x2 + y2) + 128'(ap) * 128'(ap);
        dr = root_of(s);
        dden = s * 128'(dr);
        zb = ((128'(mass_d) * 128'(mz)) << 40) / dden;
        if (zb >= 128'(dbgf_pkg::LIM47)) mzd = 64'(dbgf_pkg::LIM47);
        else mzd = clip47((zb * 128'(ap)) / 128'(q));
        r = root_of(128'(x2 + y2 + z2));
        rp = r != 0 ? r : 64'd1;
        p = r + core_r;
        if (p == 0) p = 1;
        pden = 128'(p) * 128'(p) * 128'(rp);
        ax_d = clip47(((128'(mass_d) * 128'(mx)) << 40) / dden);
        ay_d = clip47(((128'(mass_d) * 128'(my)) << 40) / dden);
        ax_b = clip47(((128'(mass_b) * 128'(mx)) << 40) / pden);
        ay_b = clip47(((128'(mass_b) * 128'(my)) << 40) / pden);
        az_b = clip47(((128'(mass_b) * 128'(mz)) << 40) / pden);
        f.acc_x = sat48(against(px < 0, ax_d) + against(px < 0, ax_b));
        f.acc_y = sat48(against(py < 0, ay_d) + against(py < 0, ay_b));
        f.acc_z = sat48(against(pz < 0, mzd) + against(pz < 0, az_b));
        f.potential = sat48(-$signed(clip47(128'((mass_d << 24) / dr)))
                            - $signed(clip47(128'((mass_b << 24) / p))));
        return f;
    endfunction

    task automatic report(input string what, input logic [dbgf_pkg::RES_W-1:0] got,
                          input logic [dbgf_pkg::RES_W-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        dbgf_tb_pkg::t_field want;
        if (!i_rst_n) begin
            scale_a <= 64'(dbgf_pkg::RST_DISK_A);
            scale_b <= 64'(dbgf_pkg::RST_DISK_B);
            mass_d  <= 64'(dbgf_pkg::RST_DISK_M);
            core_r  <= 64'(dbgf_pkg::RST_BULGE_R);
            mass_b  <= 64'(dbgf_pkg::RST_BULGE_M);
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    dbgf_pkg::CFG_DISK_A:  scale_a <= 64'(i_cfg.data);
                    dbgf_pkg::CFG_DISK_B:  scale_b <= 64'(i_cfg.data);
                    dbgf_pkg::CFG_DISK_M:  mass_d  <= 64'(i_cfg.data);
                    dbgf_pkg::CFG_BULGE_R: core_r  <= 64'(i_cfg.data);
                    dbgf_pkg::CFG_BULGE_M: mass_b  <= 64'(i_cfg.data);
                    default: ;
                endcase
            end
            if (i_pos.valid && i_pos.ready)
                field_q.push_back(field_at(i_pos.pos_x, i_pos.pos_y, i_pos.pos_z));
            if (i_field.valid && i_field.ready) begin
                if (field_q.size() == 0) begin
                    report("unexpected result", i_field.acc_x, '0);
                end else begin
                    want = field_q.pop_front();
                    if (i_field.acc_x !== want.acc_x) report("acc_x", i_field.acc_x, want.acc_x);
                    if (i_field.acc_y !== want.acc_y) report("acc_y", i_field.acc_y, want.acc_y);
                    if (i_field.acc_z !== want.acc_z) report("acc_z", i_field.acc_z, want.acc_z);
                    if (i_field.potential !== want.potential)
                        report("potential", i_field.potential, want.potential);
                end
            end
        end
    end

    assign o_errors  = err_cnt;
    assign o_pending = field_q.size();

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: gravity field testbench
// Drives directed and random positions through several register settings and
// idle patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LATENCY  = 176;
    localparam int WDOG_MAX = 20000;
    // An index past the last register; writes to it are dropped.
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors, pending;
    int   idle_cycles = 0;
    int   send_idle, recv_stall;

    dbgf_pos_if   pos_ch();
    dbgf_field_if field_ch();
    dbgf_cfg_if   cfg_ch();

    disk_bulge_gravity_field DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_pos(pos_ch.sink), .o_field(field_ch.source), .i_cfg(cfg_ch.sink)
    );

    dbgf_scoreboard u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pos(pos_ch), .i_field(field_ch),
        .i_cfg(cfg_ch), .o_errors(errors), .o_pending(pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver with a random stall rate set per phase.
    always @(posedge i_clk)
        field_ch.ready <= ($urandom_range(99) >= recv_stall);

    always @(posedge i_clk) begin
        if ((pos_ch.valid && pos_ch.ready) || (field_ch.valid && field_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("disk_bulge_gravity_field test failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        pos_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    // Leaves valid high after the transaction so the next one can follow at once.
    task automatic send_pos(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
        while ($urandom_range(99) < send_idle) begin
            pos_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pos_ch.valid <= 1'b1;
        pos_ch.pos_x <= x; pos_ch.pos_y <= y; pos_ch.pos_z <= z;
        do @(posedge i_clk); while (!pos_ch.ready);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2097152)) - 1048576);
            2: return 32'($signed($urandom_range(262144)) - 131072);
            default: return $urandom_range(3) == 0 ? 32'h8000_0000
                          : ($urandom_range(1) ? 32'h7FFF_FFFF : 32'd0);
        endcase
    endfunction

    function automatic logic [30:0] rand_reg();
        case ($urandom_range(3))
            0: return 31'($urandom);
            1: return 31'($urandom_range(1048576));
            2: return 31'($urandom_range(131072));
            default: return $urandom_range(1) ? 31'h7FFF_FFFF : 31'd0;
        endcase
    endfunction

    logic [31:0] corner[6] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h0001_0000};

    initial begin
        pos_ch.valid = 1'b0;
        pos_ch.pos_x = '0; pos_ch.pos_y = '0; pos_ch.pos_z = '0;
        cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
        send_idle = 0; recv_stall = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: reset settings, origin and extremes of each coordinate.
        for (int i = 0; i < 6; i++) send_pos(corner[i], corner[(i + 2) % 6], corner[(i + 4) % 6]);
        send_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        drain();
        // Zero core radius and zero disk height at the origin.
        write_reg(dbgf_pkg::CFG_DISK_B, 31'd0);
        write_reg(dbgf_pkg::CFG_BULGE_R, 31'd0);
        write_reg(CFG_UNUSED, 31'h1234);
        send_pos(32'd0, 32'd0, 32'd0);
        send_pos(32'h0001_0000, 32'd0, 32'd0);
        send_pos(32'd0, 32'd0, 32'hFFFF_0000);
        drain();
        write_reg(dbgf_pkg::CFG_BULGE_M, 31'd0);
        send_pos(32'd0, 32'd0, 32'd0);
        drain();
        write_reg(dbgf_pkg::CFG_DISK_A, 31'h7FFF_FFFF);
        write_reg(dbgf_pkg::CFG_DISK_B, 31'h7FFF_FFFF);
        write_reg(dbgf_pkg::CFG_DISK_M, 31'h7FFF_FFFF);
        write_reg(dbgf_pkg::CFG_BULGE_R, 31'h7FFF_FFFF);
        write_reg(dbgf_pkg::CFG_BULGE_M, 31'h7FFF_FFFF);
        for (int i = 0; i < 6; i++) send_pos(corner[i], corner[5 - i], corner[(i + 3) % 6]);
        drain();
        // Random phases over the idle patterns, with new settings each time.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 65; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 65; end
                default: begin send_idle = 35; recv_stall = 35; end
            endcase
            write_reg(dbgf_pkg::CFG_DISK_A, rand_reg());
            write_reg(dbgf_pkg::CFG_DISK_B, rand_reg());
            write_reg(dbgf_pkg::CFG_DISK_M, rand_reg());
            write_reg(dbgf_pkg::CFG_BULGE_R, rand_reg());
            write_reg(dbgf_pkg::CFG_BULGE_M, rand_reg());
            for (int n = 0; n < 172; n++) begin
                send_pos(rand_coord(), rand_coord(), rand_coord());
                // Let the pipeline run dry once mid-phase.
                if (ph == 3 && n == 80) begin
                    pos_ch.valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
            end
            drain();
        end
        if (errors == 0)
            $display("disk_bulge_gravity_field test passed");
        else
            $display("disk_bulge_gravity_field test failed");
        $finish;
    end

endmodule
